// ----- hw/rtl/stepper_trapezoid_ramp_unit_defines.svh -----
// ---------------------------------------------------------------------------
// stepper trapezoid ramp unit assertion macros
// shared by the port checker; each macro expands to one labelled assertion
// ---------------------------------------------------------------------------
`ifndef STEPPER_TRAPEZOID_RAMP_UNIT_DEFINES_SVH
`define STEPPER_TRAPEZOID_RAMP_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define STR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define STR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/str_pkg.sv -----
// ---------------------------------------------------------------------------
// str_pkg
// types, codes and constants shared by the stepper ramp controller and datapath
// ---------------------------------------------------------------------------
`default_nettype none

package str_pkg;

	// shared divider and multiplier widths
	localparam int DIV_NW = 49;
	localparam int DIV_DW = 35;

	// motion phases as reported on motion_state
	typedef enum logic [1:0] {
		PH_STOP  = 2'd0,
		PH_ACCEL = 2'd1,
		PH_RUN   = 2'd2,
		PH_DECEL = 2'd3
	} phase_t;

	// item kinds
	localparam logic [1:0] KIND_REL  = 2'd0;
	localparam logic [1:0] KIND_ABS  = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;

	// configuration register indexes
	localparam int CFG_IW = 3;
	localparam logic [CFG_IW-1:0] CFG_MIN_DELAY   = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_FIRST_SCALE = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_SQRT_NUM    = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_ACCEL_SCALE = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_LASER_EN    = 3'd4;

	// configuration reset values
	localparam logic [31:0] RST_MIN_DELAY   = 32'd196349;
	localparam logic [15:0] RST_FIRST_SCALE = 16'd6760;
	localparam logic [31:0] RST_SQRT_NUM    = 32'd39269908;
	localparam logic [15:0] RST_ACCEL_SCALE = 16'd39;

	// fixed periods and scale
	localparam logic [31:0] MOVE_PERIOD  = 32'd50000;
	localparam logic [31:0] SHORT_DELAY  = 32'd1000;
	localparam logic [31:0] SQRT_TOP_BIT = 32'h4000_0000;

	// divide by 100 as a reciprocal multiply, exact for any 32-bit dividend
	localparam logic [31:0] PCT_RECIP = 32'h51EB_851F;
	localparam int          PCT_SHIFT = 37;

	// datapath operations
	typedef enum logic [4:0] {
		U_FLOOR,
		U_SQ_DIV,
		U_SQRT,
		U_CD_MUL,
		U_CD_DIV,
		U_SD_MUL,
		U_SD_DIV,
		U_TL_MUL,
		U_TL_DIV,
		U_AL_MUL,
		U_AL_DIV,
		U_TQ_MUL,
		U_TQ_DIV,
		U_PLAN_FIN,
		U_SHORT_FIN,
		U_TICK_PREP,
		U_TICK_DIV,
		U_TICK_FIN,
		U_NOP_FIN
	} uop_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic start;
		logic commit;
		uop_t op;
	} str_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       done;
		logic [1:0] kind;
		logic       mag_small;
		phase_t     phase;
		logic       slot_free;
	} str_sts_t;

	// operation order of a move plan and of a ramp tick
	function automatic uop_t next_uop(input uop_t op);
		uop_t nxt;
		case (op)
			U_FLOOR:     nxt = U_SQ_DIV;
			U_SQ_DIV:    nxt = U_SQRT;
			U_SQRT:      nxt = U_CD_MUL;
			U_CD_MUL:    nxt = U_CD_DIV;
			U_CD_DIV:    nxt = U_SD_MUL;
			U_SD_MUL:    nxt = U_SD_DIV;
			U_SD_DIV:    nxt = U_TL_MUL;
			U_TL_MUL:    nxt = U_TL_DIV;
			U_TL_DIV:    nxt = U_AL_MUL;
			U_AL_MUL:    nxt = U_AL_DIV;
			U_AL_DIV:    nxt = U_TQ_MUL;
			U_TQ_MUL:    nxt = U_TQ_DIV;
			U_TQ_DIV:    nxt = U_PLAN_FIN;
			U_TICK_PREP: nxt = U_TICK_DIV;
			U_TICK_DIV:  nxt = U_TICK_FIN;
			default:     nxt = U_NOP_FIN;
		endcase
		return nxt;
	endfunction

	// operations that close an item
	function automatic logic is_fin(input uop_t op);
		return (op == U_PLAN_FIN) || (op == U_SHORT_FIN) ||
			(op == U_TICK_FIN) || (op == U_NOP_FIN);
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/str_div.sv -----
// ---------------------------------------------------------------------------
// str_div
// restoring unsigned divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module str_div #(
	parameter int NW = 49,
	parameter int DW = 35
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [NW-1:0]      quotient,
	output logic [DW-1:0]      remainder
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          fits;

	// shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, divisor};

	// iteration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			cnt_q  <= CW'(NW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= DW'(trial - {1'b0, divisor});
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
			cnt_q  <= cnt_q - CW'(1);
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ----- hw/rtl/str_dp.sv -----
// ---------------------------------------------------------------------------
// str_dp
// ramp datapath: configuration, motion state, multiplier, square root,
// shared divider and the result register
// ---------------------------------------------------------------------------
`default_nettype none

module str_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire str_pkg::str_cmd_t    cmd,
	output str_pkg::str_sts_t         sts,
	input  wire logic [1:0]           kind,
	input  wire logic signed [31:0]   distance,
	input  wire logic [15:0]          acceleration,
	input  wire logic [15:0]          deceleration,
	input  wire logic [15:0]          top_speed,
	input  wire logic                 cfg_we,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [31:0]          cfg_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      step_pulse,
	output logic                      direction,
	output logic [31:0]               timer_period,
	output logic                      period_valid,
	output logic                      timer_running,
	output logic                      laser_fire,
	output logic                      laser_reset,
	output logic signed [31:0]        position,
	output logic [1:0]                motion_state
);
	import str_pkg::*;

	// configuration
	logic [31:0] mdn_q, sqn_q;
	logic [15:0] fds_q, ascale_q;
	logic        laser_en_q;

	// captured item
	logic [1:0]  kind_q;
	logic [31:0] dist_q;
	logic [15:0] acc_q, dec_q, spd_q;

	// motion state
	phase_t      phase_q;
	logic [31:0] cur_q, floor_q, dbegin_q, dcount_q, ramp_q, steps_q;
	logic [31:0] remc_q, cruise_q, pos_q;
	logic        dir_q, running_q;

	// plan temporaries
	logic [31:0] tmp_a_q, sdiv_q, top_q, acclim_q, tq_q;
	logic [16:0] root_q;
	logic [DIV_NW-1:0] prod_q;
	logic signed [34:0] num_q, den_q;
	uop_t        op_q;
	logic        one_q;

	// square root iteration
	logic [31:0] sq_x_q, sq_r_q, sq_bit_q;
	logic        sq_done_q;
	logic [32:0] sq_sum;
	logic        sq_take;

	// result register
	logic        ov_q, o_pulse_q, o_dir_q, o_pvalid_q, o_run_q, o_lfire_q, o_lreset_q;
	logic [31:0] o_period_q, o_pos_q;
	logic [1:0]  o_phase_q;

	// move geometry
	logic [31:0] step_w, mag_w;

	// unit operands
	logic [31:0] mul_a;
	logic [16:0] mul_b;
	logic [DIV_NW-1:0] div_n;
	logic [DIV_DW-1:0] div_d;
	logic        div_start, div_done;
	logic [DIV_NW-1:0] div_q;
	logic [DIV_DW-1:0] div_r;
	logic        is_mul, is_div, is_pct;
	logic [15:0] ascale_w;
	logic [34:0] num_mag, den_mag;

	// percent scaling by reciprocal
	logic [63:0] pct_prod;
	logic [31:0] pct_w;

	// tick preparation
	logic [31:0] ramp_inc;
	logic signed [34:0] ramp_x, den_acc, den_dec, num_w;

	// close of an item
	phase_t      nx_phase;
	logic [31:0] nx_cur, nx_dbegin, nx_dcount, nx_ramp, nx_steps, nx_remc, nx_cruise, nx_pos;
	logic        nx_dir, nx_run;
	logic        r_pulse, r_pvalid, r_lfire, r_lreset;
	logic [31:0] r_period;
	logic signed [36:0] q_s, nd_raw, cur_x;
	logic signed [35:0] r_s;
	logic [31:0] nd_sat, remc_sat, steps_inc;
	logic signed [33:0] dv, dv_fix, begin_w;

	// direction and magnitude of the requested move
	assign step_w = (kind_q == KIND_ABS) ? dist_q - pos_q : dist_q;
	assign mag_w  = step_w[31] ? 32'd0 - step_w : step_w;

	// operation classes
	always_comb begin
		is_mul = 1'b0;
		is_div = 1'b0;
		is_pct = 1'b0;
		case (cmd.op)
			U_CD_MUL, U_SD_MUL, U_TL_MUL, U_AL_MUL, U_TQ_MUL: is_mul = 1'b1;
			U_CD_DIV, U_SD_DIV: is_pct = 1'b1;
			U_FLOOR, U_SQ_DIV, U_TL_DIV, U_AL_DIV, U_TQ_DIV,
			U_TICK_DIV: is_div = 1'b1;
			default: ;
		endcase
	end

	assign ascale_w = (ascale_q == 16'd0) ? 16'd1 : ascale_q;

	// multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			U_CD_MUL: begin
				mul_a = {16'd0, fds_q};
				mul_b = root_q;
			end
			U_SD_MUL: begin
				mul_a = {16'd0, ascale_w};
				mul_b = {1'b0, acc_q};
			end
			U_TL_MUL: begin
				mul_a = {16'd0, spd_q};
				mul_b = {1'b0, spd_q};
			end
			U_AL_MUL: begin
				mul_a = mag_w;
				mul_b = {1'b0, dec_q};
			end
			U_TQ_MUL: begin
				mul_a = top_q;
				mul_b = {1'b0, acc_q};
			end
			default: ;
		endcase
	end

	// product over 100, taken from the low 32 bits of the product
	assign pct_prod = 64'(prod_q[31:0]) * 64'(PCT_RECIP);
	assign pct_w    = 32'(pct_prod >> PCT_SHIFT);

	// signed tick operands as magnitudes
	assign num_mag = num_q[34] ? 35'(-num_q) : 35'(num_q);
	assign den_mag = den_q[34] ? 35'(-den_q) : 35'(den_q);

	// divider operands
	always_comb begin
		div_n = '0;
		div_d = 35'd1;
		case (cmd.op)
			U_FLOOR: begin
				div_n = {17'd0, mdn_q};
				div_d = {19'd0, spd_q};
			end
			U_SQ_DIV: begin
				div_n = {17'd0, sqn_q};
				div_d = {19'd0, acc_q};
			end
			U_TL_DIV: begin
				div_n = prod_q;
				div_d = {3'd0, sdiv_q};
			end
			U_AL_DIV: begin
				div_n = prod_q;
				div_d = {18'd0, {1'b0, acc_q} + {1'b0, dec_q}};
			end
			U_TQ_DIV: begin
				div_n = prod_q;
				div_d = {19'd0, dec_q};
			end
			U_TICK_DIV: begin
				div_n = {14'd0, num_mag};
				div_d = den_mag;
			end
			default: ;
		endcase
	end

	assign div_start = cmd.start && is_div;

	str_div #(
		.NW (DIV_NW),
		.DW (DIV_DW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_n),
		.divisor   (div_d),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_r)
	);

	// square root step
	assign sq_sum  = {1'b0, sq_r_q} + {1'b0, sq_bit_q};
	assign sq_take = sq_sum <= {1'b0, sq_x_q};

	// tick preparation terms
	assign ramp_inc = ramp_q + 32'd1;
	assign ramp_x   = {{3{ramp_inc[31]}}, ramp_inc};
	assign den_acc  = {ramp_x[32:0], 2'b00} + 35'sd1;
	assign den_dec  = 35'sd1 - {ramp_x[32:0], 2'b00};
	assign num_w    = $signed({2'b00, cur_q, 1'b0}) + $signed({{3{remc_q[31]}}, remc_q});

	// signed quotient and remainder of the tick division
	assign q_s = (num_q[34] ^ den_q[34]) ? -$signed({2'b00, div_q[34:0]})
		: $signed({2'b00, div_q[34:0]});
	assign r_s = num_q[34] ? -$signed({1'b0, div_r}) : $signed({1'b0, div_r});
	assign cur_x = $signed({5'd0, cur_q});

	always_comb begin
		if (r_s < -36'sh0_8000_0000)
			remc_sat = 32'h8000_0000;
		else if (r_s > 36'sh0_7FFF_FFFF)
			remc_sat = 32'h7FFF_FFFF;
		else
			remc_sat = r_s[31:0];
	end

	// next delay before saturation, accelerating or decelerating
	assign nd_raw = (phase_q == PH_ACCEL) ? cur_x - q_s : cur_x + q_s;

	always_comb begin
		if (nd_raw < 37'sd0)
			nd_sat = 32'd0;
		else if (nd_raw > 37'sh0_FFFF_FFFF)
			nd_sat = 32'hFFFF_FFFF;
		else
			nd_sat = nd_raw[31:0];
	end

	assign steps_inc = steps_q + 32'd1;

	// deceleration span of a planned move
	assign dv = (acclim_q <= top_q) ? $signed({2'b00, acclim_q}) - $signed({2'b00, mag_w})
		: -$signed({2'b00, tq_q});
	assign dv_fix  = (dv == 34'sd0) ? -34'sd1 : dv;
	assign begin_w = $signed({2'b00, mag_w}) + dv_fix;

	// next state and result at the close of an item
	always_comb begin
		nx_phase  = phase_q;
		nx_cur    = cur_q;
		nx_dbegin = dbegin_q;
		nx_dcount = dcount_q;
		nx_ramp   = ramp_q;
		nx_steps  = steps_q;
		nx_remc   = remc_q;
		nx_cruise = cruise_q;
		nx_pos    = pos_q;
		nx_dir    = dir_q;
		nx_run    = running_q;
		r_pulse   = 1'b0;
		r_period  = '0;
		r_pvalid  = 1'b0;
		r_lfire   = 1'b0;
		r_lreset  = 1'b0;
		case (cmd.op)
			U_SHORT_FIN, U_PLAN_FIN: begin
				nx_dir = ~step_w[31];
				if (mag_w != 32'd0) begin
					r_period = MOVE_PERIOD;
					r_pvalid = 1'b1;
					nx_run   = 1'b1;
				end
				if (cmd.op == U_SHORT_FIN) begin
					// single step goes straight to the last deceleration step
					if (mag_w == 32'd1) begin
						nx_ramp  = 32'hFFFF_FFFF;
						nx_phase = PH_DECEL;
						nx_cur   = SHORT_DELAY;
					end
				end else begin
					nx_dcount = dv_fix[31:0];
					nx_dbegin = begin_w[33] ? 32'd0 : begin_w[31:0];
					nx_ramp   = 32'd0;
					if (cur_q <= floor_q) begin
						nx_cur    = floor_q;
						nx_cruise = floor_q;
						nx_phase  = PH_RUN;
					end else begin
						nx_phase = PH_ACCEL;
					end
				end
			end
			U_TICK_FIN: begin
				r_period = cur_q;
				r_pvalid = 1'b1;
				if (phase_q == PH_STOP) begin
					r_lreset = 1'b1;
					nx_steps = 32'd0;
					nx_remc  = 32'd0;
					nx_run   = 1'b0;
					nx_cur   = 32'd0;
				end else begin
					r_pulse  = 1'b1;
					r_lfire  = laser_en_q;
					nx_steps = steps_inc;
					nx_pos   = dir_q ? pos_q + 32'd1 : pos_q - 32'd1;
					case (phase_q)
						PH_ACCEL: begin
							nx_cur  = nd_sat;
							nx_remc = remc_sat;
							if (steps_inc >= dbegin_q) begin
								nx_ramp  = dcount_q;
								nx_phase = PH_DECEL;
							end else if (nd_sat <= floor_q) begin
								nx_cruise = nd_sat;
								nx_cur    = floor_q;
								nx_remc   = 32'd0;
								nx_phase  = PH_RUN;
							end
						end
						PH_RUN: begin
							nx_cur = floor_q;
							if (steps_inc >= dbegin_q) begin
								nx_ramp  = dcount_q;
								nx_cur   = cruise_q;
								nx_phase = PH_DECEL;
							end
						end
						default: begin
							nx_cur  = nd_sat;
							nx_remc = remc_sat;
							if (!ramp_q[31])
								nx_phase = PH_STOP;
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mdn_q      <= RST_MIN_DELAY;
			fds_q      <= RST_FIRST_SCALE;
			sqn_q      <= RST_SQRT_NUM;
			ascale_q   <= RST_ACCEL_SCALE;
			laser_en_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_DELAY:   mdn_q      <= cfg_data;
				CFG_FIRST_SCALE: fds_q      <= cfg_data[15:0];
				CFG_SQRT_NUM:    sqn_q      <= cfg_data;
				CFG_ACCEL_SCALE: ascale_q   <= cfg_data[15:0];
				CFG_LASER_EN:    laser_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// item capture, zero rates count as one
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			dist_q <= distance;
			acc_q  <= (acceleration == 16'd0) ? 16'd1 : acceleration;
			dec_q  <= (deceleration == 16'd0) ? 16'd1 : deceleration;
			spd_q  <= (top_speed == 16'd0) ? 16'd1 : top_speed;
		end
	end

	// operation tracking and completion of the multiply, percent and tick preparation operations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q  <= U_NOP_FIN;
			one_q <= 1'b0;
		end else begin
			one_q <= cmd.start && (is_mul || is_pct || cmd.op == U_TICK_PREP);
			if (cmd.start)
				op_q <= cmd.op;
		end
	end

	// square root unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_x_q    <= '0;
			sq_r_q    <= '0;
			sq_bit_q  <= '0;
			sq_done_q <= 1'b0;
		end else if (cmd.start && cmd.op == U_SQRT) begin
			sq_x_q    <= tmp_a_q;
			sq_r_q    <= '0;
			sq_bit_q  <= SQRT_TOP_BIT;
			sq_done_q <= 1'b0;
		end else if (sq_bit_q != '0) begin
			if (sq_take)
				sq_x_q <= sq_x_q - sq_sum[31:0];
			sq_r_q    <= (sq_r_q >> 1) + (sq_take ? sq_bit_q : 32'd0);
			sq_bit_q  <= sq_bit_q >> 2;
			sq_done_q <= (sq_bit_q == 32'd1);
		end else begin
			sq_done_q <= 1'b0;
		end
	end

	// plan temporaries
	always_ff @(posedge clk) begin
		if (cmd.start && is_mul)
			prod_q <= DIV_NW'(mul_a * mul_b);
		if (cmd.start && cmd.op == U_SD_DIV)
			sdiv_q <= pct_w;
		if (cmd.start && cmd.op == U_TICK_PREP) begin
			num_q <= num_w;
			den_q <= (phase_q == PH_ACCEL) ? den_acc : den_dec;
		end
		if (sq_done_q)
			root_q <= 17'(sq_r_q) + ((sq_r_q < sq_x_q) ? 17'd1 : 17'd0);
		if (div_done) begin
			case (op_q)
				U_SQ_DIV: tmp_a_q <= div_q[31:0];
				U_TL_DIV: begin
					if (sdiv_q == 32'd0)
						top_q <= 32'hFFFF_FFFF;
					else if (div_q[31:0] == 32'd0)
						top_q <= 32'd1;
					else
						top_q <= div_q[31:0];
				end
				U_AL_DIV: acclim_q <= (div_q[31:0] == 32'd0) ? 32'd1 : div_q[31:0];
				U_TQ_DIV: tq_q <= (div_q > DIV_NW'(32'h8000_0000)) ? 32'h8000_0000
					: div_q[31:0];
				default: ;
			endcase
		end
	end

	// motion state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_STOP;
			cur_q     <= '0;
			floor_q   <= '0;
			dbegin_q  <= '0;
			dcount_q  <= '0;
			ramp_q    <= '0;
			steps_q   <= '0;
			remc_q    <= '0;
			cruise_q  <= '0;
			pos_q     <= '0;
			dir_q     <= 1'b0;
			running_q <= 1'b0;
		end else begin
			if (div_done && op_q == U_FLOOR)
				floor_q <= div_q[31:0];
			if (cmd.start && cmd.op == U_CD_DIV)
				cur_q <= pct_w;
			if (cmd.start && cmd.op == U_TICK_PREP)
				ramp_q <= ramp_inc;
			if (cmd.commit) begin
				phase_q   <= nx_phase;
				cur_q     <= nx_cur;
				dbegin_q  <= nx_dbegin;
				dcount_q  <= nx_dcount;
				ramp_q    <= nx_ramp;
				steps_q   <= nx_steps;
				remc_q    <= nx_remc;
				cruise_q  <= nx_cruise;
				pos_q     <= nx_pos;
				dir_q     <= nx_dir;
				running_q <= nx_run;
			end
		end
	end

	// result register, loaded only when the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (cmd.commit)
			ov_q <= 1'b1;
		else if (out_ready)
			ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			o_pulse_q  <= r_pulse;
			o_dir_q    <= nx_dir;
			o_period_q <= r_period;
			o_pvalid_q <= r_pvalid;
			o_run_q    <= nx_run;
			o_lfire_q  <= r_lfire;
			o_lreset_q <= r_lreset;
			o_pos_q    <= nx_pos;
			o_phase_q  <= nx_phase;
		end
	end

	// status to the controller
	assign sts.done      = one_q || div_done || sq_done_q;
	assign sts.kind      = kind_q;
	assign sts.mag_small = mag_w <= 32'd1;
	assign sts.phase     = phase_q;
	assign sts.slot_free = !ov_q || out_ready;

	assign out_valid     = ov_q;
	assign step_pulse    = o_pulse_q;
	assign direction     = o_dir_q;
	assign timer_period  = o_period_q;
	assign period_valid  = o_pvalid_q;
	assign timer_running = o_run_q;
	assign laser_fire    = o_lfire_q;
	assign laser_reset   = o_lreset_q;
	assign position      = o_pos_q;
	assign motion_state  = o_phase_q;

endmodule

`default_nettype wire

// ----- hw/rtl/str_ctrl.sv -----
// ---------------------------------------------------------------------------
// str_ctrl
// ramp controller: accepts items and steps the datapath through its operations
// ---------------------------------------------------------------------------
`default_nettype none

module str_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire str_pkg::str_sts_t sts,
	output str_pkg::str_cmd_t      cmd
);
	import str_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECODE = 5'b00010,
		ST_ISSUE  = 5'b00100,
		ST_WAIT   = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t state_q;
	uop_t   op_q;
	uop_t   first_op;
	uop_t   nxt_op;

	// first operation of an item
	always_comb begin
		if (sts.kind == KIND_REL || sts.kind == KIND_ABS)
			first_op = sts.mag_small ? U_SHORT_FIN : U_FLOOR;
		else if (sts.kind == KIND_TICK)
			first_op = (sts.phase == PH_ACCEL || sts.phase == PH_DECEL) ? U_TICK_PREP
				: U_TICK_FIN;
		else
			first_op = U_NOP_FIN;
	end

	assign nxt_op = next_uop(op_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= U_NOP_FIN;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					op_q    <= first_op;
					state_q <= is_fin(first_op) ? ST_DONE : ST_ISSUE;
				end
				ST_ISSUE: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (sts.done) begin
						op_q    <= nxt_op;
						state_q <= is_fin(nxt_op) ? ST_DONE : ST_ISSUE;
					end
				end
				ST_DONE: begin
					if (sts.slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.load   = in_valid && (state_q == ST_IDLE);
	assign cmd.start  = (state_q == ST_ISSUE);
	assign cmd.commit = (state_q == ST_DONE) && sts.slot_free;
	assign cmd.op     = op_q;

endmodule

`default_nettype wire

// ----- hw/rtl/stepper_trapezoid_ramp_unit.sv -----
// a full move plan runs five divider passes, a square root and seven multiply
// or percent steps; zero or single-step moves, stop, run and ignored ticks
// close without a datapath operation; an accelerating or decelerating tick
// runs a preparation step and one divider pass
// one item in flight at a time; the result register frees the input before it is taken
// reset: motion state cleared, configuration to its defaults, no clearing pass
// ---------------------------------------------------------------------------
// stepper_trapezoid_ramp_unit
// trapezoidal stepper speed ramp: move planning and per-tick delay update
// ---------------------------------------------------------------------------
`default_nettype none

module stepper_trapezoid_ramp_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         kind,
	input  wire logic signed [31:0] distance,
	input  wire logic [15:0]        acceleration,
	input  wire logic [15:0]        deceleration,
	input  wire logic [15:0]        top_speed,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    step_pulse,
	output logic                    direction,
	output logic [31:0]             timer_period,
	output logic                    period_valid,
	output logic                    timer_running,
	output logic                    laser_fire,
	output logic                    laser_reset,
	output logic signed [31:0]      position,
	output logic [1:0]              motion_state,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);
	import str_pkg::*;

	str_cmd_t cmd;
	str_sts_t sts;

	// sequencer
	str_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic and state
	str_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.kind          (kind),
		.distance      (distance),
		.acceleration  (acceleration),
		.deceleration  (deceleration),
		.top_speed     (top_speed),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.step_pulse    (step_pulse),
		.direction     (direction),
		.timer_period  (timer_period),
		.period_valid  (period_valid),
		.timer_running (timer_running),
		.laser_fire    (laser_fire),
		.laser_reset   (laser_reset),
		.position      (position),
		.motion_state  (motion_state)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/str_chk.sv -----
// ---------------------------------------------------------------------------
// str_chk
// port checker for the stepper ramp unit, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "stepper_trapezoid_ramp_unit_defines.svh"

module str_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        step_pulse,
	input wire logic        period_valid,
	input wire logic        timer_running,
	input wire logic        laser_reset,
	input wire logic [31:0] position,
	input wire logic [1:0]  motion_state
);
	import str_pkg::*;

	// a waiting result stays
	`STR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	// and keeps its position
	`STR_ASSERT_NEXT(a_pos_hold, out_valid && !out_ready, $stable(position), "position changed while stalled")
	// one item at a time
	`STR_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")
	// a step only comes with a period on a running timer
	`STR_ASSERT_NOW(a_step_run, out_valid && step_pulse, period_valid && timer_running, "step without running timer")
	// laser off only on a stop tick
	`STR_ASSERT_NOW(a_laser_stop, out_valid && laser_reset, !timer_running && motion_state == PH_STOP && !step_pulse, "laser reset outside stop")

endmodule

bind stepper_trapezoid_ramp_unit str_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.step_pulse    (step_pulse),
	.period_valid  (period_valid),
	.timer_running (timer_running),
	.laser_reset   (laser_reset),
	.position      (position),
	.motion_state  (motion_state)
);

`default_nettype wire
